/* hw/rtl/tfn_pkg.sv */
// shared types and constants for the triangle flat normal block
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int LANES = 3;

  typedef struct packed {
    logic             degenerate;
    logic [LANES-1:0] neg;
  } tag_t;

endpackage

/* hw/rtl/tfn_in_if.sv */
// triangle input channel: three vertices with valid and ready
`timescale 1ns / 1ps
interface tfn_in_if #(parameter int COORD_WIDTH = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

/* hw/rtl/tfn_out_if.sv */
// normal output channel: unit normal and degenerate flag with valid and ready
`timescale 1ns / 1ps
interface tfn_out_if #(parameter int NORMAL_WIDTH = 16) ();
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  logic                           degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

/* hw/rtl/tfn_cross.sv */
// front pipeline: edges, cross product, magnitudes, squares and their sum
`timescale 1ns / 1ps
module tfn_cross #(
  parameter int W = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [W-1:0]        a [tfn_pkg::LANES],
  input  logic signed [W-1:0]        b [tfn_pkg::LANES],
  input  logic signed [W-1:0]        c [tfn_pkg::LANES],
  output logic                       out_valid,
  output logic [2*(2*W+1)-1:0]       out_sq [tfn_pkg::LANES],
  output logic [2*(2*W+1)+1:0]       out_sum,
  output tfn_pkg::tag_t              out_tag
);
  localparam int DW  = W + 1;
  localparam int NW  = 2 * DW;
  localparam int MW  = 2 * W + 1;
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;

  logic                 v1, v2, v3, v4, v5, v6;
  logic signed [DW-1:0] u1 [tfn_pkg::LANES];
  logic signed [DW-1:0] w1 [tfn_pkg::LANES];
  logic signed [NW-1:0] p2 [2*tfn_pkg::LANES];
  logic signed [NW-1:0] n3 [tfn_pkg::LANES];
  logic [MW-1:0]        m4 [tfn_pkg::LANES];
  logic [SQW-1:0]       sq5 [tfn_pkg::LANES];
  logic [SQW-1:0]       sq6 [tfn_pkg::LANES];
  logic [SW-1:0]        sum6;
  tfn_pkg::tag_t        tag4, tag5, tag6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        u1[i] <= DW'(b[i]) - DW'(a[i]);
        w1[i] <= DW'(c[i]) - DW'(a[i]);
      end
      p2[0] <= NW'(u1[1]) * NW'(w1[2]);
      p2[1] <= NW'(u1[2]) * NW'(w1[1]);
      p2[2] <= NW'(u1[2]) * NW'(w1[0]);
      p2[3] <= NW'(u1[0]) * NW'(w1[2]);
      p2[4] <= NW'(u1[0]) * NW'(w1[1]);
      p2[5] <= NW'(u1[1]) * NW'(w1[0]);
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        n3[i] <= p2[2*i] - p2[2*i+1];
      end
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        m4[i]       <= n3[i][NW-1] ? MW'(-n3[i]) : MW'(n3[i]);
        tag4.neg[i] <= n3[i][NW-1];
      end
      tag4.degenerate <= (n3[0] == '0) && (n3[1] == '0) && (n3[2] == '0);
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        sq5[i] <= SQW'(m4[i]) * SQW'(m4[i]);
      end
      tag5 <= tag4;
      sum6 <= SW'(sq5[0]) + SW'(sq5[1]) + SW'(sq5[2]);
      sq6  <= sq5;
      tag6 <= tag5;
    end
  end

  assign out_valid = v6;
  assign out_sq    = sq6;
  assign out_sum   = sum6;
  assign out_tag   = tag6;
endmodule

/* hw/rtl/tfn_div.sv */
// pipelined restoring divider, one quotient bit per stage, three lanes
`timescale 1ns / 1ps
module tfn_div #(
  parameter int SQW = 66,
  parameter int F   = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [SQW-1:0]      in_sq [tfn_pkg::LANES],
  input  logic [SQW+1:0]      in_sum,
  input  tfn_pkg::tag_t       in_tag,
  output logic                out_valid,
  output logic [2*F+2:0]      out_q [tfn_pkg::LANES],
  output tfn_pkg::tag_t       out_tag
);
  localparam int SW = SQW + 2;
  localparam int RW = SW + 1;
  localparam int NQ = 2 * F + 3;

  logic          vld [NQ+1];
  logic [RW-1:0] rem [NQ+1][tfn_pkg::LANES];
  logic [NQ-1:0] quo [NQ+1][tfn_pkg::LANES];
  logic [SW-1:0] dvs [NQ+1];
  tfn_pkg::tag_t tag [NQ+1];

  assign vld[0] = in_valid;
  assign dvs[0] = in_sum;
  assign tag[0] = in_tag;
  always_comb begin
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      rem[0][i] = RW'(in_sq[i]);
      quo[0][i] = '0;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_step
    logic [RW-1:0] sh   [tfn_pkg::LANES];
    logic          take [tfn_pkg::LANES];

    always_comb begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        sh[i]   = (k == 0) ? rem[k][i] : {rem[k][i][RW-2:0], 1'b0};
        take[i] = sh[i] >= {1'b0, dvs[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < tfn_pkg::LANES; i++) begin
          rem[k+1][i] <= take[i] ? sh[i] - {1'b0, dvs[k]} : sh[i];
          quo[k+1][i] <= {quo[k][i][NQ-2:0], take[i]};
        end
        dvs[k+1] <= dvs[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[NQ];
  assign out_q     = quo[NQ];
  assign out_tag   = tag[NQ];
endmodule

/* hw/rtl/tfn_sqrt.sv */
// pipelined integer square root, one root bit per stage, three lanes
`timescale 1ns / 1ps
module tfn_sqrt #(
  parameter int F = 14
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*F+2:0]  in_q [tfn_pkg::LANES],
  input  tfn_pkg::tag_t   in_tag,
  output logic            out_valid,
  output logic [F+1:0]    out_root [tfn_pkg::LANES],
  output tfn_pkg::tag_t   out_tag
);
  localparam int NS  = F + 2;
  localparam int QE  = 2 * NS;
  localparam int RMW = F + 5;

  logic           vld  [NS+1];
  logic [QE-1:0]  rad  [NS+1][tfn_pkg::LANES];
  logic [RMW-1:0] rem  [NS+1][tfn_pkg::LANES];
  logic [NS-1:0]  root [NS+1][tfn_pkg::LANES];
  tfn_pkg::tag_t  tag  [NS+1];

  assign vld[0] = in_valid;
  assign tag[0] = in_tag;
  always_comb begin
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      rad[0][i]  = {1'b0, in_q[i]};
      rem[0][i]  = '0;
      root[0][i] = '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [RMW-1:0] cur   [tfn_pkg::LANES];
    logic [RMW-1:0] trial [tfn_pkg::LANES];
    logic           take  [tfn_pkg::LANES];

    always_comb begin
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        cur[i]   = {rem[k][i][RMW-3:0], rad[k][i][QE-1:QE-2]};
        trial[i] = RMW'({root[k][i], 2'b01});
        take[i]  = cur[i] >= trial[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < tfn_pkg::LANES; i++) begin
          rem[k+1][i]  <= take[i] ? cur[i] - trial[i] : cur[i];
          root[k+1][i] <= {root[k][i][NS-2:0], take[i]};
          rad[k+1][i]  <= {rad[k][i][QE-3:0], 2'b00};
        end
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[NS];
  assign out_root  = root[NS];
  assign out_tag   = tag[NS];
endmodule

/* hw/rtl/triangle_flat_normal.sv */
// top level of the triangle flat normal unit
//
// takes one triangle per item on the triangle channel (vertices a, b, c as
// signed COORD_WIDTH-bit coordinates) and gives one item per triangle on the
// normal channel: the unit face normal of (b-a) x (c-a), each component
// signed with NORMAL_FRAC_BITS fraction bits, rounded to nearest, halves
// away from zero. a zero cross product gives (0, 1, 0) with degenerate set.
//
// a triangle passes in order through the front pipeline for edges, cross
// product, squares and their sum, the pipelined divider, the pipelined
// square root and an output register. one triangle is taken every cycle
// while the receiver keeps up.
//
// the whole pipeline moves as one; when the output holds an item that the
// receiver does not take, every stage holds and triangle.ready drops in the
// same cycle, so no item is lost or repeated. reset clears all valid bits
// and the block is ready in the first cycle after it.
`timescale 1ns / 1ps
module triangle_flat_normal #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic      clk,
  input logic      rst,
  tfn_in_if.sink   triangle,
  tfn_out_if.source normal
);
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NWO = F + 2;
  localparam int SQW = 2 * (2 * COORD_WIDTH + 1);
  localparam int NQ  = 2 * F + 3;

  logic                        en;
  logic                        in_valid;
  logic                        out_ready;
  logic signed [COORD_WIDTH-1:0] va [tfn_pkg::LANES];
  logic signed [COORD_WIDTH-1:0] vb [tfn_pkg::LANES];
  logic signed [COORD_WIDTH-1:0] vc [tfn_pkg::LANES];

  logic            cr_valid;
  logic [SQW-1:0]  cr_sq [tfn_pkg::LANES];
  logic [SQW+1:0]  cr_sum;
  tfn_pkg::tag_t   cr_tag;
  logic            dv_valid;
  logic [NQ-1:0]   dv_q [tfn_pkg::LANES];
  tfn_pkg::tag_t   dv_tag;
  logic            sq_valid;
  logic [F+1:0]    sq_root [tfn_pkg::LANES];
  tfn_pkg::tag_t   sq_tag;

  logic                  out_valid;
  logic signed [NWO-1:0] nrm [tfn_pkg::LANES];
  logic                  deg;
  logic [F+2:0]          rnd [tfn_pkg::LANES];
  logic [NWO-1:0]        mag [tfn_pkg::LANES];

  assign in_valid  = triangle.valid;
  assign out_ready = normal.ready;
  assign en        = !out_valid || out_ready;
  assign triangle.ready = en;

  assign va[0] = triangle.a_x;
  assign va[1] = triangle.a_y;
  assign va[2] = triangle.a_z;
  assign vb[0] = triangle.b_x;
  assign vb[1] = triangle.b_y;
  assign vb[2] = triangle.b_z;
  assign vc[0] = triangle.c_x;
  assign vc[1] = triangle.c_y;
  assign vc[2] = triangle.c_z;

  tfn_cross #(.W(COORD_WIDTH)) u_cross (
    .clk, .rst, .en, .in_valid,
    .a(va), .b(vb), .c(vc),
    .out_valid(cr_valid), .out_sq(cr_sq), .out_sum(cr_sum), .out_tag(cr_tag)
  );

  tfn_div #(.SQW(SQW), .F(F)) u_div (
    .clk, .rst, .en,
    .in_valid(cr_valid), .in_sq(cr_sq), .in_sum(cr_sum), .in_tag(cr_tag),
    .out_valid(dv_valid), .out_q(dv_q), .out_tag(dv_tag)
  );

  tfn_sqrt #(.F(F)) u_sqrt (
    .clk, .rst, .en,
    .in_valid(dv_valid), .in_q(dv_q), .in_tag(dv_tag),
    .out_valid(sq_valid), .out_root(sq_root), .out_tag(sq_tag)
  );

  // largest odd value not above the root gives the rounded component
  always_comb begin
    for (int i = 0; i < tfn_pkg::LANES; i++) begin
      rnd[i] = {1'b0, sq_root[i]} + (F+3)'(1);
      mag[i] = rnd[i][F+2:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg <= sq_tag.degenerate;
      for (int i = 0; i < tfn_pkg::LANES; i++) begin
        if (sq_tag.degenerate) begin
          nrm[i] <= (i == 1) ? NWO'(1) << F : '0;
        end else begin
          nrm[i] <= sq_tag.neg[i] ? -mag[i] : mag[i];
        end
      end
    end
  end

  assign normal.valid      = out_valid;
  assign normal.normal_x   = nrm[0];
  assign normal.normal_y   = nrm[1];
  assign normal.normal_z   = nrm[2];
  assign normal.degenerate = deg;
endmodule

/* hw/rtl/tfn_checker.sv */
// port-level checks for the triangle flat normal unit and their binding
`timescale 1ns / 1ps
module tfn_checker #(
  parameter int F = 14
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [F+1:0] nx,
  input logic signed [F+1:0] ny,
  input logic signed [F+1:0] nz,
  input logic                deg
);
  localparam logic signed [F+1:0] ONE  = (F+2)'(1) << F;
  localparam logic signed [F+1:0] MONE = -ONE;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nx) && $stable(ny) && $stable(nz)
      && $stable(deg))
    else $error("stalled item changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");

  a_fallback: assert property (@(posedge clk) disable iff (rst)
    out_valid && deg |-> nx == '0 && nz == '0 && ny == ONE)
    else $error("bad fallback normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> nx <= ONE && nx >= MONE && ny <= ONE && ny >= MONE && nz <= ONE
      && nz >= MONE && (nx != '0 || ny != '0 || nz != '0))
    else $error("normal out of range");

  a_reset: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("output valid after reset");
endmodule

bind triangle_flat_normal tfn_checker #(.F(NORMAL_FRAC_BITS)) u_tfn_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(en),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .nx(nrm[0]),
  .ny(nrm[1]),
  .nz(nrm[2]),
  .deg(deg)
);

/* tb/sv/triangle_flat_normal_tb.sv */
// testbench for triangle_flat_normal: directed table and random triangles checked by a predictor
`timescale 1ns / 1ps
module triangle_flat_normal_tb;
  localparam int FRAC = 14;
  localparam int ONE = 1 << FRAC;

  typedef struct {
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               degen;
  } norm_t;

  typedef struct {
    tri_t  t;
    bit    typed;
    norm_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   tx_idle = 25;
  int   rx_idle = 45;
  norm_t normals_due[$];
  row_t  rows[$];

  tfn_in_if #(.COORD_WIDTH(16)) triangle ();
  tfn_out_if #(.NORMAL_WIDTH(16)) normal ();

  triangle_flat_normal #(.COORD_WIDTH(16), .NORMAL_FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .triangle(triangle),
    .normal(normal)
  );

  always #5 clk = ~clk;

  // largest r in [0, ONE] with (2r-1)^2 * sumsq <= 4^(FRAC+1) * m^2
  function automatic int unit_part(logic [127:0] m, logic [127:0] sumsq);
    logic [127:0] lhs, rhs, odd;
    int lo, hi, mid;
    lo = 0;
    hi = ONE;
    rhs = (m * m) << (2 * FRAC + 2);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      odd = 128'(2 * mid - 1);
      lhs = odd * odd * sumsq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic norm_t face_normal(tri_t t);
    longint ux, uy, uz, vx, vy, vz;
    longint n[3];
    logic [127:0] mag[3];
    logic [127:0] sumsq;
    int r[3];
    norm_t res;
    ux = longint'(t.bx) - t.ax;
    uy = longint'(t.by) - t.ay;
    uz = longint'(t.bz) - t.az;
    vx = longint'(t.cx) - t.ax;
    vy = longint'(t.cy) - t.ay;
    vz = longint'(t.cz) - t.az;
    n[0] = uy * vz - uz * vy;
    n[1] = uz * vx - ux * vz;
    n[2] = ux * vy - uy * vx;
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
      res.nx = 0;
      res.ny = 16'(ONE);
      res.nz = 0;
      res.degen = 1'b1;
      return res;
    end
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = 128'(n[i] < 0 ? -n[i] : n[i]);
      sumsq = sumsq + mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      r[i] = unit_part(mag[i], sumsq);
      if (n[i] < 0) r[i] = -r[i];
    end
    res.nx = 16'(r[0]);
    res.ny = 16'(r[1]);
    res.nz = 16'(r[2]);
    res.degen = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic tri_t mk(int ax, int ay, int az, int bx, int by, int bz,
                              int cx, int cy, int cz);
    tri_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
    t.bx = 16'(bx); t.by = 16'(by); t.bz = 16'(bz);
    t.cx = 16'(cx); t.cy = 16'(cy); t.cz = 16'(cz);
    return t;
  endfunction

  function automatic void add_row(tri_t t, bit typed, int nx, int ny, int nz, bit dg);
    row_t r;
    r.t = t;
    r.typed = typed;
    r.want.nx = 16'(nx);
    r.want.ny = 16'(ny);
    r.want.nz = 16'(nz);
    r.want.degen = dg;
    rows.push_back(r);
  endfunction

  function automatic int rnd_coord(int lo, int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int kind, k, dx, dy, dz;
    kind = $urandom_range(9);
    if (kind <= 5) begin
      t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    end else if (kind <= 7) begin
      t = mk(rnd_coord(-8, 7), rnd_coord(-8, 7), rnd_coord(-8, 7),
             rnd_coord(-8, 7), rnd_coord(-8, 7), rnd_coord(-8, 7),
             rnd_coord(-8, 7), rnd_coord(-8, 7), rnd_coord(-8, 7));
    end else if (kind == 8) begin
      // collinear vertices
      dx = rnd_coord(-100, 100);
      dy = rnd_coord(-100, 100);
      dz = rnd_coord(-100, 100);
      k = rnd_coord(-5, 5);
      t = mk(0, 0, 0, dx, dy, dz, k * dx, k * dy, k * dz);
      t.ax = 16'(rnd_coord(-1000, 1000));
      t.ay = 16'(rnd_coord(-1000, 1000));
      t.az = 16'(rnd_coord(-1000, 1000));
      t.bx = t.bx + t.ax; t.by = t.by + t.ay; t.bz = t.bz + t.az;
      t.cx = t.cx + t.ax; t.cy = t.cy + t.ay; t.cz = t.cz + t.az;
    end else begin
      // two coincident vertices
      t = mk($urandom, $urandom, $urandom, 0, 0, 0, $urandom, $urandom, $urandom);
      t.bx = t.ax; t.by = t.ay; t.bz = t.az;
    end
    return t;
  endfunction

  task automatic send_tri(row_t r);
    norm_t want;
    if ($urandom_range(99) < tx_idle) begin
      triangle.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    triangle.a_x <= r.t.ax; triangle.a_y <= r.t.ay; triangle.a_z <= r.t.az;
    triangle.b_x <= r.t.bx; triangle.b_y <= r.t.by; triangle.b_z <= r.t.bz;
    triangle.c_x <= r.t.cx; triangle.c_y <= r.t.cy; triangle.c_z <= r.t.cz;
    triangle.valid <= 1'b1;
    do @(posedge clk); while (!triangle.ready);
    want = r.typed ? r.want : face_normal(r.t);
    normals_due.push_back(want);
  endtask

  always @(posedge clk) begin
    normal.ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk) begin
    norm_t want;
    if (!rst && normal.valid && normal.ready) begin
      if (normals_due.size() == 0) begin
        report_mismatch("unexpected item, normal_x", normal.normal_x, 0);
      end else begin
        want = normals_due.pop_front();
        if (normal.normal_x !== want.nx) report_mismatch("normal_x", normal.normal_x, want.nx);
        if (normal.normal_y !== want.ny) report_mismatch("normal_y", normal.normal_y, want.ny);
        if (normal.normal_z !== want.nz) report_mismatch("normal_z", normal.normal_z, want.nz);
        if (normal.degenerate !== want.degen)
          report_mismatch("degenerate", normal.degenerate, want.degen);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    row_t r;
    int total;
    int wait_cycles;
    triangle.valid = 1'b0;
    triangle.a_x = 0; triangle.a_y = 0; triangle.a_z = 0;
    triangle.b_x = 0; triangle.b_y = 0; triangle.b_z = 0;
    triangle.c_x = 0; triangle.c_y = 0; triangle.c_z = 0;
    normal.ready = 1'b0;

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, ONE, 0, 1);
    add_row(mk(0, 0, 0, 1, 0, 0, 0, 1, 0), 1, 0, 0, ONE, 0);
    add_row(mk(0, 0, 0, 0, 1, 0, 1, 0, 0), 1, 0, 0, -ONE, 0);
    add_row(mk(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0), 1, 0, 0, ONE, 0);
    add_row(mk(-32768, -32768, 0, -32768, 32767, 0, 32767, -32768, 0), 1, 0, 0, -ONE, 0);
    add_row(mk(0, -32768, -32768, 0, 32767, -32768, 0, -32768, 32767), 1, ONE, 0, 0, 0);
    add_row(mk(-32768, 0, -32768, -32768, 0, 32767, 32767, 0, -32768), 1, 0, ONE, 0, 0);
    add_row(mk(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0), 1, 0, ONE, 0, 1);
    add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1, 0, ONE, 0, 1);
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0), 1, 0, ONE, 0, 1);
    add_row(mk(1, 2, 3, 2, 4, 6, 3, 6, 9), 1, 0, ONE, 0, 1);
    add_row(mk(0, 0, 0, 1, -1, 0, 0, 1, -1), 0, 0, 0, 0, 0);
    add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768),
            0, 0, 0, 0, 0);
    add_row(mk(32767, -32768, 32767, -32768, 32767, 32767, -32768, -32768, -32768),
            0, 0, 0, 0, 0);
    add_row(mk(0, 0, 0, 3, 0, 0, 0, 4, 5), 0, 0, 0, 0, 0);
    add_row(mk(-21845, 21845, -21846, 21845, -21846, 21845, 1, -1, 1), 0, 0, 0, 0, 0);
    add_row(mk(0, 0, 0, 32767, 1, 0, 1, 32767, 1), 0, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    total = rows.size() + 1650;
    for (int i = 0; i < total; i++) begin
      if (i == total / 3) begin
        tx_idle = 45;
        rx_idle = 25;
      end else if (i == 2 * total / 3) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (i < rows.size()) begin
        r = rows[i];
      end else begin
        r.t = rand_tri();
        r.typed = 1'b0;
      end
      send_tri(r);
    end
    triangle.valid <= 1'b0;

    wait_cycles = 0;
    while (normals_due.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (errors == 0 && normals_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
